FILE: design/rqc_pkg.sv
package rqc_pkg;

    localparam int unsigned RQC_DEPTH = 128;

    localparam int ID_W   = 31;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 8;

    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_GET,
        OP_CANCEL,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id_out;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
    } t_cmd;

endpackage

FILE: design/rqc_ram.sv
module rqc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rqc_front.sv
module rqc_front
    import rqc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_op        w_op;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        case (i_item.mode)
            MODE_PUT:    w_op = OP_PUT;
            MODE_GET:    w_op = OP_GET;
            MODE_CANCEL: w_op = OP_CANCEL;
            default:     w_op = OP_NOP;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{op: w_op, id: i_item.id};
        end
    end

endmodule

FILE: design/rqc_back.sv
module rqc_back
    import rqc_pkg::*;
#(
    parameter int DEPTH = RQC_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GETRD = 4'b0010,
        S_SRCH  = 4'b0100,
        S_SHIFT = 4'b1000
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] p);
        f_prev = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [ID_W-1:0] r_id, n_id;
    logic [AW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_dst, n_dst;
    logic [CW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_ck, n_ck;
    logic            r_pend, n_pend;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [ID_W-1:0] w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [ID_W-1:0] w_rdata;
    logic            w_out_free;
    logic [CW:0]     w_sum;
    logic [CW:0]     w_tail_exp;

    rqc_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_id        = r_id;
        n_src       = r_src;
        n_dst       = r_dst;
        n_k         = r_k;
        n_ck        = r_ck;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_tail;
        w_wdata     = r_id;
        w_raddr     = r_head;
        o_cmd_pop   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    n_id      = i_cmd.id;
                    n_out     = '{status: ST_OK, id_out: '0, occupancy: OCC_W'(r_count)};
                    case (i_cmd.op)
                        OP_PUT: begin
                            n_out_valid = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_we            = 1'b1;
                                w_waddr         = r_tail;
                                w_wdata         = i_cmd.id;
                                n_tail          = f_next(r_tail);
                                n_count         = r_count + CW'(1);
                                n_out.occupancy = OCC_W'(r_count + CW'(1));
                            end
                        end
                        OP_GET: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_state = S_GETRD;
                            end
                        end
                        OP_CANCEL: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_state = S_SRCH;
                                n_src   = r_head;
                                n_k     = '0;
                                n_pend  = 1'b0;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_GETRD: begin
                n_out_valid = 1'b1;
                n_out       = '{status: ST_OK, id_out: w_rdata,
                                occupancy: OCC_W'(r_count - CW'(1))};
                n_head      = f_next(r_head);
                n_count     = r_count - CW'(1);
                n_state     = S_IDLE;
            end
            S_SRCH: begin
                w_raddr = r_src;
                n_pend  = 1'b0;
                if (r_k < r_count) begin
                    n_dst  = r_src;
                    n_ck   = r_k;
                    n_src  = f_next(r_src);
                    n_k    = r_k + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    if (w_rdata == r_id) begin
                        n_state = S_SHIFT;
                        n_dst   = r_dst;
                        n_src   = f_next(r_dst);
                        n_k     = r_ck + CW'(1);
                        n_pend  = 1'b0;
                    end else if (r_ck == r_count - CW'(1)) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_NOTFOUND, id_out: '0,
                                        occupancy: OCC_W'(r_count)};
                        n_state     = S_IDLE;
                        n_pend      = 1'b0;
                    end
                end
            end
            S_SHIFT: begin
                // read runs one slot ahead of the write that moves it toward head
                w_raddr = r_src;
                w_waddr = r_dst;
                w_wdata = w_rdata;
                n_pend  = 1'b0;
                if (r_pend) begin
                    w_we  = 1'b1;
                    n_dst = f_next(r_dst);
                end
                if (r_k < r_count) begin
                    n_src  = f_next(r_src);
                    n_k    = r_k + CW'(1);
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_tail      = f_prev(r_tail);
                    n_count     = r_count - CW'(1);
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, id_out: '0,
                                    occupancy: OCC_W'(r_count - CW'(1))};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_src <= n_src;
        r_dst <= n_dst;
        r_ck  <= n_ck;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    assign w_sum      = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign w_tail_exp = (w_sum >= (CW + 1)'(DEPTH)) ? w_sum - (CW + 1)'(DEPTH) : w_sum;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == AW'(w_tail_exp))
        else $error("tail does not match head plus count");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !o_cmd_pop) |=> (r_state == S_IDLE))
        else $error("left idle without taking a command");

    a_search_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> !w_we)
        else $error("ring written during search");

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> (r_state != S_GETRD && r_state != S_SHIFT))
        else $error("multi-cycle operation running while result is held");

endmodule

FILE: design/ring_queue_with_cancel_top.sv
// Ring FIFO of 31-bit ids with put, get and cancel-by-value. A 2-entry command
// queue decouples the input from execution; results leave through an output
// register. Put, get on empty, unused mode and the full and empty errors finish
// when the command is taken; get reads the head entry in a further state; cancel
// searches from the head and, on a match, moves each later entry one slot toward
// head to close the gap, then retracts tail, else reports not found. Execution is
// paced by the single read and single write port of the ring RAM.
module ring_queue_with_cancel_top
    import rqc_pkg::*;
#(
    parameter int DEPTH = RQC_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    rqc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    rqc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .o_item      (o_item),
        .i_stall     (i_stall)
    );

endmodule

FILE: dv/rqc_result_checker.sv
`timescale 1ns / 100ps

module rqc_result_checker
    import rqc_pkg::*;
#(
    parameter int DEPTH = RQC_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_item i_out_item,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_pending
);

    logic [ID_W-1:0] ring [DEPTH];
    int unsigned     head;
    int unsigned     tail;
    int unsigned     held;
    t_out_item       awaited_results[$];

    function automatic t_out_item ring_apply(t_in_item it);
        t_out_item   r = '0;
        int unsigned pos;
        int unsigned k;
        int unsigned j;
        int unsigned nx;
        bit          hit;
        case (it.mode)
            MODE_PUT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring[tail] = it.id;
                    tail = (tail + 1) % DEPTH;
                    held++;
                end
            end
            MODE_GET: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.id_out = ring[head];
                    head = (head + 1) % DEPTH;
                    held--;
                end
            end
            MODE_CANCEL: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = head;
                    hit = 1'b0;
                    for (k = 0; k < held; k++) begin
                        if (ring[pos] == it.id) begin
                            hit = 1'b1;
                            break;
                        end
                        pos = (pos + 1) % DEPTH;
                    end
                    if (!hit) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        // close the gap toward head, then retract tail
                        for (j = k + 1; j < held; j++) begin
                            nx = (pos + 1) % DEPTH;
                            ring[pos] = ring[nx];
                            pos = nx;
                        end
                        tail = (tail == 0) ? DEPTH - 1 : tail - 1;
                        held--;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            head         = 0;
            tail         = 0;
            held         = 0;
            o_fail_count = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: transaction with none expected, actual status %0d id %0d occ %0d",
                             $time, i_out_item.status, i_out_item.id_out, i_out_item.occupancy);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, i_out_item.status);
                    check_field("id_out", want.id_out, i_out_item.id_out);
                    check_field("occupancy", want.occupancy, i_out_item.occupancy);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(ring_apply(i_in_item));
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rqc_pkg::*;

    localparam int                N_ITEMS      = 1700;
    localparam int                QUIET_ITEMS  = 150;
    localparam int                CYCLE_LIMIT  = 2_000_000;
    localparam int                TAIL_CYCLES  = 40;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam logic [ID_W-1:0]   ID_MAX       = '1;

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } t_seg;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    int          fail_count;
    int          pending;
    int          n_sent     = 0;
    bit          quiet      = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycles     = 0;

    ring_queue_with_cancel_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_stall (in_stall),
        .o_valid (out_valid),
        .o_item  (out_item),
        .i_stall (out_stall)
    );

    rqc_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_item    (in_item),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_item   (out_item),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** ring_queue_with_cancel_top: FAILED **");
            $finish;
        end
    end

    // result-side backpressure in bursts
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end else begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 40);
        end
    end

    task automatic send(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] v);
        int gap;
        quiet = (n_sent >= N_ITEMS - QUIET_ITEMS);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_item.mode <= m;
        in_item.id   <= v;
        do @(posedge clk); while (in_stall);
        n_sent++;
    endtask

    // small pools at both ends of the range so cancels find matches
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 3))
            0:       return ID_W'($urandom_range(0, 15));
            1:       return ID_MAX - ID_W'($urandom_range(0, 15));
            2:       return ID_W'($urandom);
            default: return ID_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(t_seg seg);
        int r;
        r = $urandom_range(0, 99);
        case (seg)
            SEG_FILL: begin
                if (r < 88) return MODE_PUT;
                if (r < 96) return MODE_CANCEL;
                if (r < 99) return MODE_GET;
            end
            SEG_DRAIN: begin
                if (r < 65) return MODE_GET;
                if (r < 90) return MODE_CANCEL;
                if (r < 97) return MODE_PUT;
            end
            default: begin
                if (r < 40) return MODE_PUT;
                if (r < 65) return MODE_GET;
                if (r < 95) return MODE_CANCEL;
            end
        endcase
        return MODE_UNUSED;
    endfunction

    initial begin
        t_seg seg;
        int   len;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(MODE_GET, ID_MAX);
        send(MODE_CANCEL, '0);
        send(MODE_UNUSED, ID_MAX);
        send(MODE_PUT, '0);
        send(MODE_PUT, ID_MAX);
        send(MODE_PUT, 31'd5);
        send(MODE_PUT, 31'd5);
        send(MODE_CANCEL, 31'd5);
        send(MODE_CANCEL, 31'd5);
        send(MODE_CANCEL, 31'd1234);
        send(MODE_UNUSED, '0);
        send(MODE_GET, '0);
        send(MODE_GET, '0);
        send(MODE_GET, '0);
        send(MODE_PUT, 31'd42);
        send(MODE_CANCEL, 31'd42);
        send(MODE_PUT, 31'd1);
        send(MODE_PUT, 31'd2);
        send(MODE_PUT, 31'd3);
        send(MODE_CANCEL, 31'd1);
        send(MODE_GET, '0);
        send(MODE_CANCEL, 31'd3);

        while (n_sent < N_ITEMS) begin
            seg = t_seg'($urandom_range(0, 3) > 2 ? SEG_MIX : $urandom_range(0, 2));
            len = (seg == SEG_FILL) ? $urandom_range(150, 200) : $urandom_range(20, 120);
            repeat (len) begin
                if (n_sent < N_ITEMS) send(pick_mode(seg), pick_id());
            end
        end
        in_valid <= 1'b0;

        // let the count of the last accepted transaction settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** ring_queue_with_cancel_top: PASSED **");
        end else begin
            $display("** ring_queue_with_cancel_top: FAILED **");
        end
        $finish;
    end

endmodule
